// ===== src/ccu8_pkg.sv =====
// Package for the case-converting UTF-8 encoder.
// Holds the case mode codes and the code point constants shared by the design.
// Depends on nothing.
package ccu8_pkg;

  localparam int unsigned CpWidth   = 21;
  localparam int unsigned ByteWidth = 8;

  typedef enum logic [1:0] {
    MODE_NONE       = 2'd0,
    MODE_CAPITALIZE = 2'd1,
    MODE_UPPER      = 2'd2,
    MODE_LOWER      = 2'd3
  } mode_e;

  typedef logic [CpWidth-1:0]   cp_t;
  typedef logic [ByteWidth-1:0] byte_t;

  // Index of the last byte of an encoding: 0 for one byte up to 3 for four.
  typedef logic [1:0] byte_idx_t;

  localparam cp_t CpSpace   = 21'h00020;
  localparam cp_t CpTab     = 21'h00009;
  localparam cp_t CpNewline = 21'h0000A;

  localparam cp_t LatinUpLo = 21'h00041;
  localparam cp_t LatinUpHi = 21'h0005A;
  localparam cp_t LatinLoLo = 21'h00061;
  localparam cp_t LatinLoHi = 21'h0007A;
  localparam cp_t CyrUpLo   = 21'h00410;
  localparam cp_t CyrUpHi   = 21'h0042F;
  localparam cp_t CyrLoLo   = 21'h00430;
  localparam cp_t CyrLoHi   = 21'h0044F;
  localparam cp_t CyrExUpLo = 21'h00400;
  localparam cp_t CyrExUpHi = 21'h0040F;
  localparam cp_t CyrExLoLo = 21'h00450;
  localparam cp_t CyrExLoHi = 21'h0045F;
  localparam cp_t CaseStep  = 21'h00020;
  localparam cp_t CaseStepEx = 21'h00050;

  localparam cp_t Limit1Byte = 21'h00080;
  localparam cp_t Limit2Byte = 21'h00800;
  localparam cp_t Limit3Byte = 21'h10000;

endpackage

// ===== src/ccu8_cp_if.sv =====
// Handshake channel that carries one decoded code point per item.
// Depends on ccu8_pkg.
interface ccu8_cp_if;
  logic              valid;
  logic              ready;
  ccu8_pkg::cp_t     code_point;
  logic              first_of_text;

  modport source (output valid, output code_point, output first_of_text, input ready);
  modport sink   (input valid, input code_point, input first_of_text, output ready);
endinterface

// ===== src/ccu8_byte_if.sv =====
// Handshake channel that carries one UTF-8 byte per item with a last flag.
// Depends on ccu8_pkg.
interface ccu8_byte_if;
  logic              valid;
  logic              ready;
  ccu8_pkg::byte_t   out_byte;
  logic              last_byte;

  modport source (output valid, output out_byte, output last_byte, input ready);
  modport sink   (input valid, input out_byte, input last_byte, output ready);
endinterface

// ===== src/case_convert_utf8_encode_top.sv =====
// Top level of the case-converting UTF-8 encoder.
// Depends on ccu8_pkg, ccu8_cp_if and ccu8_byte_if.
//
// Channel      Dir   Payload                         Handshake
// cp_i         in    code_point[20:0], first_of_text valid/ready
// byte_o       out   out_byte[7:0], last_byte        valid/ready
// text_mode_*  in    text_mode[1:0]                  write enable only
//
// An item is case-converted and registered in the cycle it is accepted; its
// one to four bytes then leave one per cycle from the held code point while
// byte_o is ready. A new item is taken in the same cycle as the last byte of
// the previous one, and not while earlier bytes of the held item remain.
// Reset clears the held item, sets the new-word flag and the mode to none.
// A stall on byte_o holds the current byte and blocks cp_i.
module case_convert_utf8_encode_top (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              text_mode_we_i,
  input  logic [1:0]        text_mode_i,
  ccu8_cp_if.sink           cp_i,
  ccu8_byte_if.source       byte_o
);
  import ccu8_pkg::*;

  mode_e     mode_q;
  logic      new_word_q, new_word_d;
  logic      valid_q, valid_d;
  cp_t       cp_q, cp_d;
  byte_idx_t cnt_q, cnt_d;
  byte_idx_t idx_q, idx_d;

  logic      in_acc, out_acc, last;
  logic      ws_eff, do_upper, do_lower;
  cp_t       cp_in, cp_up, cp_lo;
  byte_idx_t grp;
  logic [5:0] cont_bits;

  // Case conversion of the incoming code point.
  always_comb begin
    cp_in = cp_i.code_point;
    cp_up = cp_in;
    if ((cp_in >= LatinLoLo && cp_in <= LatinLoHi) ||
        (cp_in >= CyrLoLo && cp_in <= CyrLoHi)) begin
      cp_up = cp_in - CaseStep;
    end else if (cp_in >= CyrExLoLo && cp_in <= CyrExLoHi) begin
      cp_up = cp_in - CaseStepEx;
    end
    cp_lo = cp_in;
    if ((cp_in >= LatinUpLo && cp_in <= LatinUpHi) ||
        (cp_in >= CyrUpLo && cp_in <= CyrUpHi)) begin
      cp_lo = cp_in + CaseStep;
    end else if (cp_in >= CyrExUpLo && cp_in <= CyrExUpHi) begin
      cp_lo = cp_in + CaseStepEx;
    end
    ws_eff   = cp_i.first_of_text | new_word_q;
    do_upper = (mode_q == MODE_UPPER) || ((mode_q == MODE_CAPITALIZE) && ws_eff);
    do_lower = (mode_q == MODE_LOWER);
  end

  assign last       = (idx_q == cnt_q);
  assign out_acc    = byte_o.valid & byte_o.ready;
  assign cp_i.ready = ~valid_q | (byte_o.ready & last);
  assign in_acc     = cp_i.valid & cp_i.ready;

  always_comb begin
    cp_d       = cp_q;
    cnt_d      = cnt_q;
    idx_d      = idx_q;
    valid_d    = valid_q;
    new_word_d = new_word_q;
    if (out_acc) begin
      idx_d = idx_q + byte_idx_t'(1);
      if (last) begin
        valid_d = 1'b0;
      end
    end
    if (in_acc) begin
      priority if (do_upper) begin
        cp_d = cp_up;
      end else if (do_lower) begin
        cp_d = cp_lo;
      end else begin
        cp_d = cp_in;
      end
      new_word_d = (cp_d == CpSpace) || (cp_d == CpTab) || (cp_d == CpNewline);
      priority if (cp_d < Limit1Byte) begin
        cnt_d = byte_idx_t'(0);
      end else if (cp_d < Limit2Byte) begin
        cnt_d = byte_idx_t'(1);
      end else if (cp_d < Limit3Byte) begin
        cnt_d = byte_idx_t'(2);
      end else begin
        cnt_d = byte_idx_t'(3);
      end
      idx_d   = '0;
      valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= MODE_NONE;
      new_word_q <= 1'b1;
      valid_q    <= 1'b0;
      cnt_q      <= '0;
      idx_q      <= '0;
    end else begin
      if (text_mode_we_i) begin
        mode_q <= mode_e'(text_mode_i);
      end
      new_word_q <= new_word_d;
      valid_q    <= valid_d;
      cnt_q      <= cnt_d;
      idx_q      <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cp_q <= cp_d;
  end

  // Byte selection: the lead byte at index zero, else the six-bit group
  // counted from the low end of the code point.
  assign grp = cnt_q - idx_q;

  always_comb begin
    unique case (grp)
      2'd0:    cont_bits = cp_q[5:0];
      2'd1:    cont_bits = cp_q[11:6];
      2'd2:    cont_bits = cp_q[17:12];
      default: cont_bits = 6'd0;
    endcase
  end

  always_comb begin
    if (idx_q != byte_idx_t'(0)) begin
      byte_o.out_byte = {2'b10, cont_bits};
    end else begin
      unique case (cnt_q)
        2'd0:    byte_o.out_byte = {1'b0, cp_q[6:0]};
        2'd1:    byte_o.out_byte = {3'b110, cp_q[10:6]};
        2'd2:    byte_o.out_byte = {4'b1110, cp_q[15:12]};
        default: byte_o.out_byte = {5'b11110, cp_q[20:18]};
      endcase
    end
  end

  assign byte_o.valid     = valid_q;
  assign byte_o.last_byte = last;

  // The byte index never runs past the byte count of the held item.
  assert property (@(posedge clk_i) disable iff (!rst_ni) valid_q |-> (idx_q <= cnt_q))
    else $error("byte index past the end of the encoding");

  // A new item is only taken once the held one has delivered its last byte.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (in_acc && valid_q) |-> (out_acc && last))
    else $error("item accepted over an unfinished encoding");

  // After a byte that is not the last, the next byte of the same item follows.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (out_acc && !last) |=> (valid_q && idx_q == $past(idx_q) + byte_idx_t'(1)))
    else $error("encoding cut short");

  // A single-byte encoding never has the top bit set.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (valid_q && cnt_q == byte_idx_t'(0)) |-> !byte_o.out_byte[7])
    else $error("single byte encoding out of range");

endmodule
